// ----- rtl/core/sdspi_pkg.sv -----
// Shared types and constants for the SD card SPI-mode command engine.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package sdspi_pkg;

    // Input word kinds (carried on tuser)
    localparam logic [1:0] KIND_START = 2'd0;
    localparam logic [1:0] KIND_XFER  = 2'd1;
    localparam logic [1:0] KIND_TICK  = 2'd2;

    // Command bytes, with start bits, held without the application flag
    localparam logic [6:0] BYTE_CMD0  = 7'h40;
    localparam logic [6:0] BYTE_CMD8  = 7'h48;
    localparam logic [6:0] BYTE_CMD55 = 7'h77;

    // CRC bytes and the idle fill byte
    localparam logic [7:0] CRC_CMD0  = 8'h95;
    localparam logic [7:0] CRC_CMD8  = 8'h87;
    localparam logic [7:0] CRC_OTHER = 8'h01;
    localparam logic [7:0] FILL_BYTE = 8'hFF;

    // Frame byte positions
    localparam logic [2:0] IDX_CS_HIGH = 3'd0;
    localparam logic [2:0] IDX_CS_LOW  = 3'd1;
    localparam logic [2:0] IDX_CMD     = 3'd2;
    localparam logic [2:0] IDX_ARG3    = 3'd3;
    localparam logic [2:0] IDX_ARG2    = 3'd4;
    localparam logic [2:0] IDX_ARG1    = 3'd5;
    localparam logic [2:0] IDX_ARG0    = 3'd6;
    localparam logic [2:0] IDX_CRC     = 3'd7;

    // Configuration
    localparam logic [9:0] TIMEOUT_RESET = 10'd5;
    localparam logic [1:0] REG_TIMEOUT   = 2'd0;
    localparam logic [9:0] ELAPSED_MAX   = 10'd1023;

    // Request to the frame byte selector
    typedef struct packed {
        logic        prefix;
        logic [6:0]  command;
        logic [31:0] argument;
        logic [2:0]  index;
    } frame_req_t;

    // One result word
    typedef struct packed {
        logic       timed_out;
        logic [7:0] response;
        logic       done_res;
        logic       chip_select_n;
        logic [7:0] tx_byte;
        logic       tx_valid;
    } result_t;

endpackage

// ----- rtl/core/sdspi_frame.sv -----
// Frame byte selector: picks the byte sent at one position of a command frame.
// Depends on sdspi_pkg.
`timescale 1ns / 1ps

module sdspi_frame (
    input  sdspi_pkg::frame_req_t req,
    output logic [7:0]            frame_byte
);
    import sdspi_pkg::*;

    logic [6:0]  cmd;
    logic [31:0] arg;
    logic [7:0]  crc;

    // Substitute CMD55 with a zero argument while the prefix is pending
    assign cmd = req.prefix ? BYTE_CMD55 : req.command;
    assign arg = req.prefix ? 32'd0 : req.argument;

    // CRC is only checked by the card for CMD0 and CMD8
    always_comb begin
        if (cmd == BYTE_CMD0) begin
            crc = CRC_CMD0;
        end else if (cmd == BYTE_CMD8) begin
            crc = CRC_CMD8;
        end else begin
            crc = CRC_OTHER;
        end
    end

    // Select the byte; argument goes out most significant first
    always_comb begin
        case (req.index)
            IDX_CS_HIGH, IDX_CS_LOW: frame_byte = FILL_BYTE;
            IDX_CMD:                 frame_byte = {1'b0, cmd};
            IDX_ARG3:                frame_byte = arg[31:24];
            IDX_ARG2:                frame_byte = arg[23:16];
            IDX_ARG1:                frame_byte = arg[15:8];
            IDX_ARG0:                frame_byte = arg[7:0];
            default:                 frame_byte = crc;
        endcase
    end

endmodule

// ----- rtl/core/sdspi_ctrl.sv -----
// Command sequencer: holds the command state, advances it per accepted word
// and forms the result word. Depends on sdspi_pkg and sdspi_frame.
`timescale 1ns / 1ps

module sdspi_ctrl (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 accept,
    input  logic [1:0]           kind,
    input  logic [7:0]           cmd_code,
    input  logic [31:0]          argument,
    input  logic [7:0]           rx_byte,
    input  logic [9:0]           timeout_ms,
    output sdspi_pkg::result_t   result
);
    import sdspi_pkg::*;

    localparam logic [1:0] PH_IDLE  = 2'd0;
    localparam logic [1:0] PH_FRAME = 2'd1;
    localparam logic [1:0] PH_POLL  = 2'd2;

    logic [1:0]  phase_reg, phase_next;
    logic [2:0]  idx_reg, idx_next;
    logic [6:0]  cmd_reg, cmd_next;
    logic [31:0] arg_reg, arg_next;
    logic        prefix_reg, prefix_next;
    logic [9:0]  elapsed_reg, elapsed_next;
    logic        expired_reg, expired_next;

    logic        finish;
    logic        finish_to;
    logic        resp_ok;
    logic [9:0]  elapsed_inc;
    frame_req_t  req;
    logic [7:0]  frame_byte;

    assign resp_ok     = ~rx_byte[7];
    assign elapsed_inc = (elapsed_reg != ELAPSED_MAX) ? elapsed_reg + 10'd1 : elapsed_reg;

    // Advance the command state for one accepted word
    always_comb begin
        phase_next   = phase_reg;
        idx_next     = idx_reg;
        cmd_next     = cmd_reg;
        arg_next     = arg_reg;
        prefix_next  = prefix_reg;
        elapsed_next = elapsed_reg;
        expired_next = expired_reg;
        finish       = 1'b0;
        finish_to    = 1'b0;
        if (accept) begin
            case (kind)
                KIND_START: begin
                    if (phase_reg == PH_IDLE) begin
                        prefix_next = cmd_code[7];
                        cmd_next    = cmd_code[6:0];
                        arg_next    = argument;
                        idx_next    = IDX_CS_HIGH;
                        phase_next  = PH_FRAME;
                    end
                end
                KIND_XFER: begin
                    if (phase_reg == PH_FRAME) begin
                        if (idx_reg != IDX_CRC) begin
                            idx_next = idx_reg + 3'd1;
                        end else begin
                            phase_next   = PH_POLL;
                            elapsed_next = '0;
                            expired_next = 1'b0;
                        end
                    end else if (phase_reg == PH_POLL) begin
                        if (resp_ok || expired_reg) begin
                            prefix_next = 1'b0;
                            idx_next    = IDX_CS_HIGH;
                            // CMD55 accepted: go on to the main frame
                            if (prefix_reg && (rx_byte <= 8'd1)) begin
                                phase_next = PH_FRAME;
                            end else begin
                                phase_next = PH_IDLE;
                                finish     = 1'b1;
                                finish_to  = ~resp_ok;
                            end
                        end
                    end
                end
                KIND_TICK: begin
                    // Timer runs only while polling
                    if (phase_reg == PH_POLL) begin
                        elapsed_next = elapsed_inc;
                        if (elapsed_inc >= timeout_ms) begin
                            expired_next = 1'b1;
                        end
                    end
                end
                default: begin
                end
            endcase
        end
    end

    // Byte of the frame position that follows
    assign req.prefix   = prefix_next;
    assign req.command  = cmd_next;
    assign req.argument = arg_next;
    assign req.index    = idx_next;

    sdspi_frame u_frame (
        .req        (req),
        .frame_byte (frame_byte)
    );

    // Form the result word from the new state
    always_comb begin
        result = '0;
        if (finish) begin
            result.done_res  = 1'b1;
            result.response  = rx_byte;
            result.timed_out = finish_to;
        end else begin
            case (phase_next)
                PH_FRAME: begin
                    result.tx_valid      = 1'b1;
                    result.tx_byte       = frame_byte;
                    result.chip_select_n = (idx_next == IDX_CS_HIGH);
                end
                PH_POLL: begin
                    result.tx_valid = 1'b1;
                    result.tx_byte  = FILL_BYTE;
                end
                default: begin
                    result.chip_select_n = 1'b1;
                end
            endcase
        end
    end

    // Control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg   <= PH_IDLE;
            idx_reg     <= '0;
            cmd_reg     <= '0;
            arg_reg     <= '0;
            prefix_reg  <= 1'b0;
            elapsed_reg <= '0;
            expired_reg <= 1'b0;
        end else begin
            phase_reg   <= phase_next;
            idx_reg     <= idx_next;
            cmd_reg     <= cmd_next;
            arg_reg     <= arg_next;
            prefix_reg  <= prefix_next;
            elapsed_reg <= elapsed_next;
            expired_reg <= expired_next;
        end
    end

endmodule

// ----- rtl/core/sd_spi_command_engine_top.sv -----
// SD card SPI-mode command engine top level: input handshake, configuration
// register, result register. Depends on sdspi_pkg and sdspi_ctrl.
`timescale 1ns / 1ps

// Usage:
//   s_ channel: one word per event. s_tuser selects the kind: start a command
//   (cmd_code and argument used), an SPI byte exchange finished (rx_byte is
//   the byte read back) or a one millisecond tick.
//   m_ channel: exactly one result word per accepted input word, giving the
//   next byte to exchange and chip select, or the finished R1 response.
//   APB port: register 0 at address 0 is the response timeout in ms.
// Timing: a result word appears in the cycle after its input word is accepted.
// Throughput: one word per cycle unless stalled; the state update and result
//   are formed in a single pass between the held state and the result register.
// Reset: the engine returns to idle with the timeout at 5 ms and no result
//   pending.
// Stall: a result waits in the output register while m_tready is low; a new
//   input word is taken in the same cycle the waiting result leaves, and
//   s_tready stays low only while a result is held and not taken.
module sd_spi_command_engine_top (
    input  logic        aclk,
    input  logic        aresetn,
    // Input words
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [47:0] s_tdata,   // cmd_code[7:0], argument[39:8], rx_byte[47:40]
    input  logic [1:0]  s_tuser,   // kind[1:0]
    // Result words
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // tx_valid[0], tx_byte[8:1], chip_select_n[9],
                                   // done_res[10], response[18:11], timed_out[19], zero
    // Configuration
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [1:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import sdspi_pkg::*;

    logic       accept;
    logic [9:0] timeout_reg;
    logic       m_tvalid_reg;
    result_t    result;
    result_t    res_reg;

    // Accept while the result register is empty or draining
    assign s_tready = ~m_tvalid_reg | m_tready;
    assign accept   = s_tvalid & s_tready;

    // Timeout register
    assign pready = 1'b1;
    assign prdata = (paddr == REG_TIMEOUT) ? {22'd0, timeout_reg} : 32'd0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            timeout_reg <= TIMEOUT_RESET;
        end else if (psel && penable && pwrite && pready && (paddr == REG_TIMEOUT)) begin
            timeout_reg <= pwdata[9:0];
        end
    end

    sdspi_ctrl u_ctrl (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .accept     (accept),
        .kind       (s_tuser),
        .cmd_code   (s_tdata[7:0]),
        .argument   (s_tdata[39:8]),
        .rx_byte    (s_tdata[47:40]),
        .timeout_ms (timeout_reg),
        .result     (result)
    );

    // Result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (accept) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            res_reg <= result;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {4'd0, res_reg.timed_out, res_reg.response, res_reg.done_res,
                       res_reg.chip_select_n, res_reg.tx_byte, res_reg.tx_valid};

    // Every accepted word yields a result word in the next cycle
    a_result_follows: assert property (@(posedge aclk) disable iff (!aresetn)
        accept |=> m_tvalid)
        else $error("accepted word produced no result");

    // A finishing word requests no exchange and keeps the card selected
    a_done_idle_bus: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && res_reg.done_res) |-> (!res_reg.tx_valid && !res_reg.chip_select_n))
        else $error("finish word requests an exchange or deselects the card");

    // An exchange with the card deselected only ever sends the fill byte
    a_cs_high_fill: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && res_reg.tx_valid && res_reg.chip_select_n)
            |-> (res_reg.tx_byte == FILL_BYTE))
        else $error("deselected exchange carries data");

endmodule
